// ----- rtl/quoted_token_splitter_macros.svh -----
// Assertion macros shared by the quoted token splitter RTL.
// Each macro expects clk and rst_n in scope of the module that uses it.
`ifndef QUOTED_TOKEN_SPLITTER_MACROS_SVH
`define QUOTED_TOKEN_SPLITTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/qts_pkg.sv -----
// Package for the quoted token splitter: constants, event codes and result types.
// Used by qts_fifo, qts_scan and quoted_token_splitter; depends on nothing.
package qts_pkg;

  localparam int MAX_LINE   = 1024;
  localparam int MAX_TOKENS = 64;
  localparam int POS_W      = $clog2(MAX_LINE);
  localparam int TF_W       = $clog2(MAX_TOKENS + 1);
  localparam int IDX_W      = $clog2(MAX_TOKENS);
  localparam int Q_DEPTH    = 4;
  localparam int PTR_W      = $clog2(Q_DEPTH);
  localparam int QCNT_W     = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] EV_START = 2'd0;
  localparam logic [1:0] EV_DELIM = 2'd1;
  localparam logic [1:0] EV_DONE  = 2'd2;
  localparam logic [1:0] EV_ERROR = 2'd3;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5c;

  typedef struct packed {
    logic [1:0]       event_res;
    logic [POS_W-1:0] position;
    logic [IDX_W-1:0] token_index;
    logic [TF_W-1:0]  token_count;
    logic             last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic res_t mk_res(logic [1:0] ev, logic [POS_W-1:0] pos,
                                  logic [IDX_W-1:0] idx, logic [TF_W-1:0] cnt);
    res_t r;
    r.event_res   = ev;
    r.position    = pos;
    r.token_index = idx;
    r.token_count = cnt;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

// ----- rtl/qts_fifo.sv -----
// Result queue of the quoted token splitter: takes up to two results per cycle,
// hands out one per handshake. Depends on qts_pkg and the assertion macros.
`include "quoted_token_splitter_macros.svh"

module qts_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  qts_pkg::push_t push,
  output logic           space2,
  output logic           out_valid,
  input  logic           out_ready,
  output qts_pkg::res_t  head
);
  import qts_pkg::*;

  res_t              q_r [Q_DEPTH];
  logic [PTR_W-1:0]  wr_r, wr_nxt;
  logic [PTR_W-1:0]  rd_r, rd_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              pop;
  logic [PTR_W-1:0]  wr_p1;

  assign out_valid = (count_r != '0);
  assign head      = q_r[rd_r];
  assign space2    = (count_r <= QCNT_W'(Q_DEPTH - 2));
  assign pop       = out_valid && out_ready;
  assign wr_p1     = wr_r + PTR_W'(1);

  always_comb begin
    wr_nxt    = wr_r + PTR_W'(push.n);
    rd_nxt    = pop ? rd_r + PTR_W'(1) : rd_r;
    count_nxt = count_r + QCNT_W'(push.n) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      q_r[wr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      q_r[wr_p1] <= push.r1;
    end
  end

  `QTS_ASSERT_NOW(a_push_room, push.n != 2'd0, space2, "push without room in result queue")
  `QTS_ASSERT_NOW(a_count_max, 1'b1, count_r <= QCNT_W'(Q_DEPTH), "result queue overfilled")
  `QTS_ASSERT_NEXT(a_pop_dec, pop && push.n == 2'd0, count_r == $past(count_r) - QCNT_W'(1),
    "result queue count did not drop on a pop")

endmodule

// ----- rtl/qts_scan.sv -----
// Line scanner of the quoted token splitter: mode state and per-character decode
// into up to two results. Depends on qts_pkg and the assertion macros.
`include "quoted_token_splitter_macros.svh"

module qts_scan (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     fire,
  input  logic [7:0]               ch,
  input  logic [qts_pkg::TF_W-1:0] max_tokens,
  output qts_pkg::push_t           push
);
  import qts_pkg::*;

  typedef enum logic [4:0] {
    M_BETWEEN = 5'b00001,
    M_PLAIN   = 5'b00010,
    M_QUOTED  = 5'b00100,
    M_AFTERQ  = 5'b01000,
    M_DISCARD = 5'b10000
  } mode_t;

  mode_t            mode_r, mode_nxt;
  logic             qd_r, qd_nxt;
  logic             pb_r, pb_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [TF_W-1:0]  tf_r, tf_nxt;

  logic [TF_W-1:0]  limit;
  logic [TF_W-1:0]  tf_inc;
  logic             white, eol, is_quote, match, ends;
  logic [1:0]       n;
  res_t             r0, r1;

  always_comb begin
    limit    = (max_tokens > TF_W'(MAX_TOKENS)) ? TF_W'(MAX_TOKENS) : max_tokens;
    tf_inc   = tf_r + TF_W'(1);
    white    = (ch == CH_SPACE) || (ch == CH_TAB);
    eol      = (ch == CH_NUL) || (ch == CH_NL);
    is_quote = (ch == CH_SQUOTE) || (ch == CH_DQUOTE);
    match    = qd_r ? (ch == CH_DQUOTE) : (ch == CH_SQUOTE);
    mode_nxt = mode_r;
    qd_nxt   = qd_r;
    pb_nxt   = pb_r;
    tf_nxt   = tf_r;
    ends     = 1'b0;
    n        = 2'd0;
    r0       = mk_res(EV_START, pos_r, '0, '0);
    r1       = mk_res(EV_DONE, pos_r, '0, tf_r);
    unique case (mode_r)
      M_BETWEEN: begin
        if (white) begin
          n = 2'd0;
        end else if (eol || ch == CH_HASH || tf_r >= limit) begin
          n  = 2'd1;
          r0 = mk_res(EV_DONE, pos_r, '0, tf_r);
          if (eol) begin
            ends = 1'b1;
          end else begin
            mode_nxt = M_DISCARD;
          end
        end else begin
          n      = 2'd1;
          r0     = mk_res(EV_START, pos_r, tf_r[IDX_W-1:0], '0);
          tf_nxt = tf_inc;
          if (tf_inc >= limit) begin
            n        = 2'd2;
            r1       = mk_res(EV_DONE, pos_r, '0, tf_inc);
            mode_nxt = M_DISCARD;
          end else if (is_quote) begin
            mode_nxt = M_QUOTED;
            qd_nxt   = (ch == CH_DQUOTE);
            pb_nxt   = 1'b0;
          end else begin
            mode_nxt = M_PLAIN;
          end
        end
      end
      M_PLAIN: begin
        if (white) begin
          n        = 2'd1;
          r0       = mk_res(EV_DELIM, pos_r, '0, '0);
          mode_nxt = M_BETWEEN;
        end else if (ch == CH_NL) begin
          n    = 2'd2;
          r0   = mk_res(EV_DELIM, pos_r, '0, '0);
          ends = 1'b1;
        end else if (ch == CH_NUL) begin
          n    = 2'd1;
          r0   = mk_res(EV_DONE, pos_r, '0, tf_r);
          ends = 1'b1;
        end
      end
      M_QUOTED: begin
        if (match && !pb_r) begin
          mode_nxt = M_AFTERQ;
          pb_nxt   = 1'b0;
        end else if (eol) begin
          n    = 2'd1;
          r0   = mk_res(EV_ERROR, pos_r, '0, '0);
          ends = 1'b1;
        end else begin
          pb_nxt = (ch == CH_BSLASH);
        end
      end
      M_AFTERQ: begin
        n = 2'd1;
        if (white) begin
          r0       = mk_res(EV_DELIM, pos_r, '0, '0);
          mode_nxt = M_BETWEEN;
        end else begin
          r0 = mk_res(EV_ERROR, pos_r, '0, '0);
          if (eol) begin
            ends = 1'b1;
          end else begin
            mode_nxt = M_DISCARD;
          end
        end
      end
      M_DISCARD: begin
        ends = eol;
      end
      default: begin
        ends = 1'b1;
      end
    endcase
    r0.last = (n == 2'd1);
    r1.last = 1'b1;
    if (ends) begin
      mode_nxt = M_BETWEEN;
      qd_nxt   = 1'b0;
      pb_nxt   = 1'b0;
      tf_nxt   = '0;
      pos_nxt  = '0;
    end else if (pos_r != POS_W'(MAX_LINE - 1)) begin
      pos_nxt = pos_r + POS_W'(1);
    end else begin
      pos_nxt = pos_r;
    end
    push.n  = fire ? n : 2'd0;
    push.r0 = r0;
    push.r1 = r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_BETWEEN;
      qd_r   <= 1'b0;
      pb_r   <= 1'b0;
      pos_r  <= '0;
      tf_r   <= '0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      qd_r   <= qd_nxt;
      pb_r   <= pb_nxt;
      pos_r  <= pos_nxt;
      tf_r   <= tf_nxt;
    end
  end

  `QTS_ASSERT_NOW(a_pair_done, push.n == 2'd2, push.r1.event_res == EV_DONE,
    "second result of a character is not line done")
  `QTS_ASSERT_NOW(a_tf_max, 1'b1, tf_r <= TF_W'(MAX_TOKENS), "token count above limit")
  `QTS_ASSERT_NEXT(a_pos_sat, fire && pos_r == POS_W'(MAX_LINE - 1) && !ends,
    pos_r == POS_W'(MAX_LINE - 1), "position did not saturate")

endmodule

// ----- rtl/quoted_token_splitter.sv -----
// Quoted token splitter: one line character per item in, token events out.
// Each accepted item is registered, then decoded once the result queue has room for two.
// Throughput: one item per cycle while out_ready holds and each item gives at most one
// result; an item giving two needs two output handshakes, set by the one-result output port.
// Reset (rst_n low, synchronous) empties all stages and sets max_tokens to 64.
module quoted_token_splitter (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_ch,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_event_res,
  output logic [qts_pkg::POS_W-1:0] out_position,
  output logic [qts_pkg::IDX_W-1:0] out_token_index,
  output logic [qts_pkg::TF_W-1:0]  out_token_count,
  output logic                      out_last,
  input  logic                      cfg_we,
  input  logic [qts_pkg::TF_W-1:0]  cfg_wdata
);
  import qts_pkg::*;

  logic            in_valid_r, in_valid_nxt;
  logic [7:0]      ch_r;
  logic [TF_W-1:0] max_tokens_r;
  logic            space2;
  logic            fire;
  logic            take;
  push_t           push;
  res_t            head;

  assign fire     = in_valid_r && space2;
  assign in_ready = !in_valid_r || fire;
  assign take     = in_valid && in_ready;

  always_comb begin
    if (take) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end else begin
      in_valid_nxt = in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      max_tokens_r <= TF_W'(MAX_TOKENS);
    end else begin
      in_valid_r <= in_valid_nxt;
      if (cfg_we) begin
        max_tokens_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ch_r <= in_ch;
    end
  end

  qts_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .ch         (ch_r),
    .max_tokens (max_tokens_r),
    .push       (push)
  );

  qts_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space2    (space2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_event_res   = head.event_res;
  assign out_position    = head.position;
  assign out_token_index = head.token_index;
  assign out_token_count = head.token_count;
  assign out_last        = head.last;

endmodule

// ----- sim/qts_checker.sv -----
// Checker for the quoted token splitter: watches the input, result and configuration ports.
// Predicts the token events of each accepted item, compares results in order, counts failures.
// Depends on qts_pkg for widths, event codes and character codes.
module qts_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [7:0]                in_ch,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [1:0]                out_event_res,
  input  logic [qts_pkg::POS_W-1:0] out_position,
  input  logic [qts_pkg::IDX_W-1:0] out_token_index,
  input  logic [qts_pkg::TF_W-1:0]  out_token_count,
  input  logic                      out_last,
  input  logic                      cfg_we,
  input  logic [qts_pkg::TF_W-1:0]  cfg_wdata,
  output int                        fails,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import qts_pkg::*;

  typedef enum logic [4:0] {
    LINE_GAP    = 5'b00001,
    LINE_WORD   = 5'b00010,
    LINE_QUOTE  = 5'b00100,
    LINE_CLOSED = 5'b01000,
    LINE_SKIP   = 5'b10000
  } line_mode_t;

  line_mode_t       mode;
  logic             quote_dq;
  logic             after_bslash;
  logic [POS_W-1:0] col;
  logic [TF_W-1:0]  found;
  logic [TF_W-1:0]  token_cap;
  res_t             events_q[$];
  res_t             oldest;

  function automatic res_t token_event(logic [1:0] ev, logic [POS_W-1:0] pos,
                                       logic [IDX_W-1:0] idx, logic [TF_W-1:0] cnt);
    res_t r;
    r.event_res   = ev;
    r.position    = pos;
    r.token_index = idx;
    r.token_count = cnt;
    r.last        = 1'b0;
    return r;
  endfunction

  task automatic new_line();
    mode         = LINE_GAP;
    quote_dq     = 1'b0;
    after_bslash = 1'b0;
    col          = '0;
    found        = '0;
  endtask

  task automatic predict_char(input logic [7:0] c);
    res_t            ev [2];
    int              n;
    logic [TF_W-1:0] lim;
    logic            blank;
    logic            eol;
    logic            line_end;
    lim      = (token_cap > TF_W'(MAX_TOKENS)) ? TF_W'(MAX_TOKENS) : token_cap;
    blank    = (c == CH_SPACE) || (c == CH_TAB);
    eol      = (c == CH_NUL) || (c == CH_NL);
    line_end = 1'b0;
    n        = 0;
    case (mode)
      LINE_GAP: begin
        if (!blank) begin
          if (eol || c == CH_HASH) begin
            ev[n] = token_event(EV_DONE, col, '0, found);
            n++;
            if (eol) line_end = 1'b1;
            else mode = LINE_SKIP;
          end else if (found >= lim) begin
            ev[n] = token_event(EV_DONE, col, '0, found);
            n++;
            mode = LINE_SKIP;
          end else begin
            ev[n] = token_event(EV_START, col, found[IDX_W-1:0], '0);
            n++;
            found++;
            if (found >= lim) begin
              ev[n] = token_event(EV_DONE, col, '0, found);
              n++;
              mode = LINE_SKIP;
            end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
              mode         = LINE_QUOTE;
              quote_dq     = (c == CH_DQUOTE);
              after_bslash = 1'b0;
            end else begin
              mode = LINE_WORD;
            end
          end
        end
      end
      LINE_WORD: begin
        if (blank) begin
          ev[n] = token_event(EV_DELIM, col, '0, '0);
          n++;
          mode = LINE_GAP;
        end else if (c == CH_NL) begin
          ev[n] = token_event(EV_DELIM, col, '0, '0);
          n++;
          ev[n] = token_event(EV_DONE, col, '0, found);
          n++;
          line_end = 1'b1;
        end else if (c == CH_NUL) begin
          ev[n] = token_event(EV_DONE, col, '0, found);
          n++;
          line_end = 1'b1;
        end
      end
      LINE_QUOTE: begin
        if (c == (quote_dq ? CH_DQUOTE : CH_SQUOTE) && !after_bslash) begin
          mode         = LINE_CLOSED;
          after_bslash = 1'b0;
        end else if (eol) begin
          ev[n] = token_event(EV_ERROR, col, '0, '0);
          n++;
          line_end = 1'b1;
        end else begin
          after_bslash = (c == CH_BSLASH);
        end
      end
      LINE_CLOSED: begin
        if (blank) begin
          ev[n] = token_event(EV_DELIM, col, '0, '0);
          n++;
          mode = LINE_GAP;
        end else begin
          ev[n] = token_event(EV_ERROR, col, '0, '0);
          n++;
          if (eol) line_end = 1'b1;
          else mode = LINE_SKIP;
        end
      end
      default: begin
        if (eol) line_end = 1'b1;
      end
    endcase
    if (line_end) begin
      new_line();
    end else if (col != POS_W'(MAX_LINE - 1)) begin
      col++;
    end
    if (n > 0) ev[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) events_q.push_back(ev[i]);
  endtask

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      token_cap = TF_W'(MAX_TOKENS);
      new_line();
      events_q.delete();
      fails = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (events_q.size() == 0) begin
          $error("result with no item pending: event_res %0d, position %0d",
                 out_event_res, out_position);
          fails++;
        end else begin
          oldest = events_q.pop_front();
          check_field("event_res", oldest.event_res, out_event_res);
          check_field("position", oldest.position, out_position);
          check_field("token_index", oldest.token_index, out_token_index);
          check_field("token_count", oldest.token_count, out_token_count);
          check_field("last", oldest.last, out_last);
        end
      end
      if (cfg_we) token_cap = cfg_wdata;
      if (in_valid && in_ready) predict_char(in_ch);
    end
    pending = events_q.size();
  end

endmodule

// ----- sim/tb_quoted_token_splitter.sv -----
// Testbench top for quoted_token_splitter: clock, reset, line stimulus and the verdict.
// Feeds directed and random configuration lines under several token limits.
// Depends on qts_pkg, the block itself and qts_checker.
module tb_quoted_token_splitter;
  timeunit 1ns;
  timeprecision 1ps;
  import qts_pkg::*;

  localparam int ITEMS_PER_PHASE = 2;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int SETTLE          = 8;
  localparam int LONG_RUN        = 1026;
  localparam int CAPS [7]        = '{5, 1, 0, 127, 2, 64, 3};

  localparam logic [7:0] OPENING [26] = '{
    CH_TAB, "a", CH_HASH, CH_SPACE, CH_DQUOTE, CH_BSLASH, CH_DQUOTE, CH_DQUOTE,
    CH_SPACE, CH_SQUOTE, "q", CH_SQUOTE, "z", CH_NL,
    "b", CH_NL,
    "d", CH_NUL,
    CH_DQUOTE, CH_NL,
    CH_SQUOTE, CH_SQUOTE, CH_NL,
    CH_HASH, "c", CH_NL
  };

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [7:0]        in_ch     = CH_NUL;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_event_res;
  logic [POS_W-1:0]  out_position;
  logic [IDX_W-1:0]  out_token_index;
  logic [TF_W-1:0]   out_token_count;
  logic              out_last;
  logic              cfg_we    = 1'b0;
  logic [TF_W-1:0]   cfg_wdata = '0;

  int         fails;
  int         pending;
  bit         sender_gaps;
  bit         recv_stalls;
  bit         hold_req;
  int         hold_left;
  int         stall_left;
  int         idle_cycles;
  int         sent;
  logic [7:0] line_q[$];

  always #5 clk = ~clk;

  quoted_token_splitter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_ch           (in_ch),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_res   (out_event_res),
    .out_position    (out_position),
    .out_token_index (out_token_index),
    .out_token_count (out_token_count),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  qts_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_ch           (in_ch),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_res   (out_event_res),
    .out_position    (out_position),
    .out_token_index (out_token_index),
    .out_token_count (out_token_count),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fails           (fails),
    .pending         (pending)
  );

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (recv_stalls && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 17);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[quoted_token_splitter] ERROR");
        $finish;
      end
    end
  end

  task automatic send_char(input logic [7:0] c);
    if (sender_gaps && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_ch    <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_char(line_q[i]);
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_cap(input int value);
    cfg_wdata <= TF_W'(value);
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic add_blank();
    line_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endtask

  function automatic logic [7:0] word_char(input bit lead);
    logic [7:0] c;
    c = CH_SPACE;
    while (c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_NUL ||
           (lead && (c == CH_HASH || c == CH_DQUOTE || c == CH_SQUOTE)))
      c = $urandom_range(0, 1) ? 8'($urandom_range(97, 122)) : 8'($urandom_range(1, 255));
    return c;
  endfunction

  function automatic logic [7:0] quote_char();
    logic [7:0] c;
    c = CH_NL;
    while (c == CH_NL) begin
      case ($urandom_range(0, 7))
        0:       c = CH_BSLASH;
        1:       c = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
        2:       c = CH_SPACE;
        default: c = 8'($urandom_range(1, 255));
      endcase
    end
    return c;
  endfunction

  task automatic build_line();
    int         kind;
    int         ntok;
    bit         quoted;
    logic [7:0] q;
    logic [7:0] c;
    line_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 16)) line_q.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) line_q.push_back(CH_NL);
      return;
    end
    ntok = ($urandom_range(0, 39) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 6);
    if ($urandom_range(0, 2) == 0) add_blank();
    for (int i = 0; i < ntok; i++) begin
      quoted = (ntok < 60) && ($urandom_range(0, 2) == 0);
      if (quoted) begin
        q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
        line_q.push_back(q);
        repeat ($urandom_range(0, 6)) begin
          c = quote_char();
          if (c == q) line_q.push_back(CH_BSLASH);
          line_q.push_back(c);
        end
        if (line_q[$] == CH_BSLASH) line_q.push_back("a");
        line_q.push_back(q);
      end else begin
        line_q.push_back(word_char(1'b1));
        repeat ((ntok < 60) ? $urandom_range(0, 5) : 0) line_q.push_back(word_char(1'b0));
      end
      if (i < ntok - 1 || quoted || $urandom_range(0, 3) == 0) add_blank();
    end
    case ($urandom_range(0, 3))
      0, 1: line_q.push_back(CH_NL);
      2:    line_q.push_back(CH_NUL);
      default: begin
        if (line_q.size() > 0 && line_q[$] != CH_SPACE && line_q[$] != CH_TAB) add_blank();
        line_q.push_back(CH_HASH);
        repeat ($urandom_range(0, 5)) line_q.push_back(8'($urandom_range(11, 255)));
        line_q.push_back(CH_NL);
      end
    endcase
    if (kind < 30) begin
      repeat ($urandom_range(1, 2))
        line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
    end
  endtask

  initial begin
    int cap_val;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    sender_gaps = 1'b1;
    recv_stalls = 1'b1;
    foreach (OPENING[i]) send_char(OPENING[i]);
    in_valid <= 1'b0;
    for (int p = 0; p < 8; p++) begin
      drain();
      cap_val = (p < 7) ? CAPS[p] : $urandom_range(0, 127);
      write_cap(cap_val);
      if (p == 7) begin
        sender_gaps = 1'b0;
        recv_stalls = 1'b0;
      end
      if (p == 0) hold_req = 1'b1;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        build_line();
        send_line();
      end
      if (p == 3) begin
        // A line longer than the position range, so that positions saturate.
        line_q.delete();
        line_q.push_back("a");
        repeat (LONG_RUN) line_q.push_back(word_char(1'b0));
        line_q.push_back(CH_SPACE);
        line_q.push_back("b");
        line_q.push_back(CH_SPACE);
        line_q.push_back(CH_DQUOTE);
        line_q.push_back("q");
        line_q.push_back(CH_DQUOTE);
        line_q.push_back(CH_NL);
        send_line();
      end
      in_valid <= 1'b0;
    end
    drain();
    if (fails == 0) begin
      $display("[quoted_token_splitter] OK");
    end else begin
      $display("[quoted_token_splitter] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/qts_pkg.sv
rtl/qts_fifo.sv
rtl/qts_scan.sv
rtl/quoted_token_splitter.sv
sim/qts_checker.sv
sim/tb_quoted_token_splitter.sv
